@@ sv/sprite_rle_frame_decoder_top_macros.svh @@
// Assertion macros shared by the sprite RLE decoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef SPRITE_RLE_FRAME_DECODER_TOP_MACROS_SVH
`define SPRITE_RLE_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/srle_pkg.sv @@
// Shared types, constants and helpers for the sprite RLE frame decoder.
// No dependencies.
package srle_pkg;

	localparam int unsigned MAX_DIM  = 2048;
	localparam int unsigned DIM_W    = 12;
	localparam int unsigned LIT_W    = 7;
	localparam int unsigned OFF_W    = 22;
	localparam int unsigned QDEPTH   = 4;
	localparam int unsigned QAW      = $clog2(QDEPTH);
	localparam int unsigned QCW      = $clog2(QDEPTH + 1);

	localparam logic [7:0]       END_OF_ROW = 8'h80;
	localparam logic [DIM_W-1:0] COL_MAX    = {DIM_W{1'b1}};
	localparam logic [DIM_W-1:0] DIM_LIMIT  = DIM_W'(MAX_DIM);

	// Configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FLIP   = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             flip;
	} cfg_t;

	// One literal pixel waiting for its address
	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [7:0]       pal;
	} pix_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_LIMIT) ? DIM_LIMIT : v;
	endfunction

	function automatic logic [DIM_W-1:0] sat_add(input logic [DIM_W-1:0] a,
			input logic [LIT_W-1:0] b);
		logic [DIM_W:0] sum;
		sum = {1'b0, a} + {{(DIM_W + 1 - LIT_W){1'b0}}, b};
		return sum[DIM_W] ? COL_MAX : sum[DIM_W-1:0];
	endfunction

endpackage

@@ sv/sprite_rle_frame_decoder_top.sv @@
// Top level of the sprite RLE frame decoder: config registers, front, queue, back.
// Depends on srle_pkg, srle_front, srle_fifo, srle_back.
//
//  port group   dir   width       contents
//  s_*          in    8 + 1       coded byte word, frame start flag in tuser
//  m_*          out   32 + 1      pixel offset and palette index, outside flag in tuser
//  cfg_*        in    2 + 12      register index and write data
//
// One coded byte is taken per cycle while the queue is not full; a literal is queued when its
// byte is taken. The single row*width multiply in the back end is registered into the output.
// A four-entry queue decouples the byte front end from the output; s_tready drops
// only when that queue is full. Reset clears position, run count and queue; registers
// come up as width 1, height 1, no flip.
module sprite_rle_frame_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] coded_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [21:0] pixel_offset, [29:22] palette_index, [31:30] zero
	output logic        m_tuser,   // [0] outside_frame
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import srle_pkg::*;

	cfg_t             cfg_q;
	logic             q_full, q_empty, q_push, q_pop;
	pix_t             q_wdata, q_rdata;
	logic [OFF_W-1:0] offset;
	logic [7:0]       pal;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(1);
			cfg_q.height <= DIM_W'(1);
			cfg_q.flip   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= cfg_data;
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_FLIP:   cfg_q.flip   <= cfg_data[0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	srle_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	srle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	srle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_offset  (offset),
		.out_pal     (pal),
		.out_outside (m_tuser)
	);

	assign m_tdata = {2'b00, pal, offset};

endmodule

@@ sv/srle_front.sv @@
// Front end: accepts coded bytes, tracks column/row/run state, queues literals.
// Depends on srle_pkg.
`include "sprite_rle_frame_decoder_top_macros.svh"

module srle_front (
	input  logic              clk,
	input  logic              arst_n,
	input  srle_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_start,
	input  logic              q_full,
	output logic              q_push,
	output srle_pkg::pix_t    q_data
);
	import srle_pkg::*;

	logic [DIM_W-1:0] col_q, row_q;
	logic [LIT_W-1:0] lit_q;
	logic [DIM_W-1:0] col_base, row_base, col_n, row_n, h_eff;
	logic [LIT_W-1:0] lit_base, lit_n;
	logic             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign h_eff    = eff_dim(cfg.height);

	always_comb begin
		// Frame start clears column and run count and sets the start row before the byte is decoded
		col_base = in_start ? '0 : col_q;
		lit_base = in_start ? '0 : lit_q;
		row_base = in_start ? (cfg.flip ? '0 : h_eff - 1'b1) : row_q;
		col_n = col_base;
		row_n = row_base;
		lit_n = lit_base;
		q_push = 1'b0;
		if (lit_base != '0) begin
			q_push = accept;
			col_n = sat_add(col_base, LIT_W'(1));
			lit_n = lit_base - 1'b1;
		end else if (in_byte == END_OF_ROW) begin
			col_n = '0;
			row_n = cfg.flip ? row_base + 1'b1 : row_base - 1'b1;
		end else if (in_byte[7]) begin
			col_n = sat_add(col_base, in_byte[LIT_W-1:0]);
		end else begin
			lit_n = in_byte[LIT_W-1:0];
		end
		q_data.row = row_base;
		q_data.col = col_base;
		q_data.pal = in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			lit_q <= '0;
		end else if (accept) begin
			col_q <= col_n;
			row_q <= row_n;
			lit_q <= lit_n;
		end
	end

	`SRLE_ASSERT_NEXT(a_lit_count_down, clk, arst_n, accept && !in_start && lit_q != '0, lit_q == $past(lit_q) - 1'b1, "literal count did not step down")
	`SRLE_ASSERT_NOW(a_push_only_in_run, clk, arst_n, q_push, accept && (in_start || lit_q != '0) && !in_start, "literal queued outside a run")

endmodule

@@ sv/srle_fifo.sv @@
// Short queue of literal pixels between front and back ends.
// Depends on srle_pkg.
`include "sprite_rle_frame_decoder_top_macros.svh"

module srle_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  srle_pkg::pix_t wdata,
	input  logic           pop,
	output srle_pkg::pix_t rdata,
	output logic           full,
	output logic           empty
);
	import srle_pkg::*;

	pix_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign full  = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`SRLE_ASSERT_NOW(a_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`SRLE_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !empty, "pop from empty queue")
	`SRLE_ASSERT_NEXT(a_count_grows, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

@@ sv/srle_back.sv @@
// Back end: forms pixel offset and bounds flag, holds the output word.
// Depends on srle_pkg.
module srle_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srle_pkg::cfg_t               cfg,
	input  logic                         q_empty,
	input  srle_pkg::pix_t               q_data,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [srle_pkg::OFF_W-1:0]   out_offset,
	output logic [7:0]                   out_pal,
	output logic                         out_outside
);
	import srle_pkg::*;

	logic [DIM_W-1:0]   w_eff, h_eff;
	logic [2*DIM_W-1:0] prod;
	logic [2*DIM_W-1:0] addr;
	logic               outside;
	logic               valid_q;
	logic [OFF_W-1:0]   offset_q;
	logic [7:0]         pal_q;
	logic               outside_q;

	assign w_eff   = eff_dim(cfg.width);
	assign h_eff   = eff_dim(cfg.height);
	assign outside = (q_data.col >= w_eff) || (q_data.row >= h_eff);
	assign prod    = q_data.row * w_eff;
	assign addr    = prod + {{DIM_W{1'b0}}, q_data.col};
	// Advance when the output word is free or being taken
	assign q_pop   = !q_empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			offset_q  <= outside ? '0 : addr[OFF_W-1:0];
			pal_q     <= q_data.pal;
			outside_q <= outside;
		end
	end

	assign out_valid   = valid_q;
	assign out_offset  = offset_q;
	assign out_pal     = pal_q;
	assign out_outside = outside_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sprite_rle_frame_decoder_top: directed and random coded byte streams,
// with every pixel write checked against a behavioral decoder. Depends on srle_pkg and the RTL.
module tb;
	import srle_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;	// no register behind it, writes are ignored
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE = 8;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 11;
	localparam int PHASE_BYTES = 75;
	localparam int FRAME_MIXED = 0;
	localparam int FRAME_LITERAL = 1;
	localparam int FRAME_SKIP = 2;

	typedef struct {
		logic [7:0] code;
		logic       start;
	} coded_word_t;

	typedef struct {
		logic [OFF_W-1:0] offset;
		logic [7:0]       pal;
		logic             outside;
	} pixel_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;	// [7:0] coded_byte
	logic        s_tuser = 1'b0;	// [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;		// [21:0] pixel_offset, [29:22] palette_index, [31:30] zero
	logic        m_tuser;		// [0] outside_frame
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = REG_WIDTH;
	logic [11:0] cfg_data = '0;

	coded_word_t  byte_q[$];
	pixel_write_t writes_due[$];

	// decoder registers and position as the block should hold them
	logic [DIM_W-1:0] frame_w = DIM_W'(1);
	logic [DIM_W-1:0] frame_h = DIM_W'(1);
	logic             flip = 1'b0;
	logic [DIM_W-1:0] cur_col = '0;
	logic [DIM_W-1:0] cur_row = '0;
	logic [6:0]       lits_left = '0;

	int src_gap, sink_gap, src_odds, sink_odds;
	int hold_req, hold_seen, quiet;
	int mismatches, writes_checked, outside_seen, bytes_fed, settings_used;

	sprite_rle_frame_decoder_top u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void decode_coded_word(input coded_word_t w);
		logic [DIM_W-1:0] w_lim, h_lim;
		logic [DIM_W:0]   col_next;
		logic [OFF_W-1:0] row_x, wid_x, col_x;
		pixel_write_t     pw;
		w_lim = (frame_w > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_w;
		h_lim = (frame_h > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_h;
		if (w.start) begin
			cur_col = '0;
			lits_left = '0;
			cur_row = flip ? '0 : h_lim - 1'b1;
		end
		if (lits_left != 0) begin
			row_x = OFF_W'(cur_row);
			wid_x = OFF_W'(w_lim);
			col_x = OFF_W'(cur_col);
			pw.outside = (cur_col >= w_lim) || (cur_row >= h_lim);
			pw.offset = pw.outside ? '0 : row_x * wid_x + col_x;
			pw.pal = w.code;
			writes_due.push_back(pw);
			col_next = {1'b0, cur_col} + 1'b1;
			cur_col = col_next[DIM_W] ? '1 : col_next[DIM_W-1:0];
			lits_left = lits_left - 1'b1;
		end else if (w.code == END_OF_ROW) begin
			cur_col = '0;
			cur_row = flip ? cur_row + 1'b1 : cur_row - 1'b1;
		end else if (w.code[7]) begin
			col_next = {1'b0, cur_col} + w.code[6:0];
			cur_col = col_next[DIM_W] ? '1 : col_next[DIM_W-1:0];
		end else begin
			lits_left = w.code[6:0];
		end
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch: %s", $realtime, msg);
	endtask

	// source side: hold a word until taken, then advance
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			decode_coded_word(byte_q.pop_front());
			bytes_fed++;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() != 0 && $urandom_range(0, 99) < src_odds) begin
				src_gap = $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else if (byte_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= byte_q[0].code;
				s_tuser <= byte_q[0].start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side: check each pixel write, stall in bursts
	always @(posedge clk) begin
		pixel_write_t want;
		if (m_tvalid && m_tready) begin
			if (writes_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected write off=%0d pal=%02h out=%0b",
					m_tdata[21:0], m_tdata[29:22], m_tuser));
			end else begin
				want = writes_due.pop_front();
				writes_checked++;
				if (m_tuser)
					outside_seen++;
				if (m_tdata[21:0] !== want.offset || m_tdata[29:22] !== want.pal ||
						m_tdata[31:30] !== 2'b00 || m_tuser !== want.outside)
					flag_mismatch($sformatf(
						"expected off=%0d pal=%02h out=%0b, got off=%0d pal=%02h out=%0b pad=%0b",
						want.offset, want.pal, want.outside,
						m_tdata[21:0], m_tdata[29:22], m_tuser, m_tdata[31:30]));
			end
		end
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			sink_gap = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < sink_odds) begin
			sink_gap = $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WIDTH:  frame_w = val;
			REG_HEIGHT: frame_h = val;
			REG_FLIP:   flip = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || s_tvalid || writes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic void queue_word(input logic [7:0] code, input logic start);
		coded_word_t w;
		w.code = code;
		w.start = start;
		byte_q.push_back(w);
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return DIM_W'(MAX_DIM);
			2: return '1;
			3: return DIM_W'($urandom);
			4: return DIM_W'($urandom_range(MAX_DIM - 8, MAX_DIM));
			default: return DIM_W'($urandom_range(1, 40));
		endcase
	endfunction

	// one frame of well-formed runs, with a little noise and a few cut-off runs
	function automatic int queue_sprite_frame(input int n_bytes, input int style);
		int pick, run, k, lit_pct, eor_pct, used;
		lit_pct = (style == FRAME_LITERAL) ? 80 : (style == FRAME_SKIP) ? 15 : 45;
		eor_pct = (style == FRAME_MIXED) ? 15 : (style == FRAME_LITERAL) ? 5 : 0;
		queue_word(8'($urandom_range(0, 255)), 1'b1);
		used = 1;
		while (used < n_bytes) begin
			pick = $urandom_range(0, 99);
			if (pick < lit_pct) begin
				if ($urandom_range(0, 99) < 4)
					run = $urandom_range(64, 127);
				else
					run = $urandom_range(1, (style == FRAME_LITERAL) ? 40 : 8);
				queue_word(8'(run), 1'b0);
				for (k = 0; k < run; k++)
					queue_word(8'($urandom_range(0, 255)), 1'b0);
				used += run + 1;
			end else if (pick < lit_pct + eor_pct) begin
				queue_word(END_OF_ROW, 1'b0);
				used++;
			end else if (pick < 93) begin
				queue_word(8'((style == FRAME_SKIP) ? $urandom_range(8'hF0, 8'hFF)
					: $urandom_range(8'h81, 8'hFF)), 1'b0);
				used++;
			end else if (pick < 95) begin
				queue_word(8'h00, 1'b0);
				used++;
			end else if (pick < 97) begin
				// cut the run short with a new frame
				run = $urandom_range(2, 10);
				queue_word(8'(run), 1'b0);
				for (k = 0; k < run / 2; k++)
					queue_word(8'($urandom_range(0, 255)), 1'b0);
				queue_word(8'($urandom_range(0, 255)), 1'b1);
				used += run / 2 + 2;
			end else begin
				queue_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				used++;
			end
		end
		return used;
	endfunction

	initial begin
		int phase, queued, style;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: one pixel frame, bottom-up, row wraps below zero
		@(negedge clk);
		queue_word(8'h02, 1'b1);
		queue_word(8'hAB, 1'b0);
		queue_word(8'h54, 1'b0);
		queue_word(END_OF_ROW, 1'b0);
		queue_word(8'h01, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(8'h00, 1'b0);
		wait_drained();
		settings_used++;

		// oversize width, full height, top-down; literals that look like control bytes
		write_reg(REG_WIDTH, 12'hFFF);
		write_reg(REG_HEIGHT, 12'd2048);
		write_reg(REG_FLIP, 12'd1);
		write_reg(REG_SPARE, 12'hABC);
		@(negedge clk);
		queue_word(8'h05, 1'b1);
		queue_word(8'h00, 1'b0);
		queue_word(8'hFF, 1'b0);
		queue_word(END_OF_ROW, 1'b0);
		queue_word(8'h7F, 1'b0);
		queue_word(8'h01, 1'b0);
		queue_word(END_OF_ROW, 1'b0);
		queue_word(8'h03, 1'b0);
		queue_word(8'h11, 1'b0);
		queue_word(8'h02, 1'b1);
		queue_word(8'h22, 1'b0);
		queue_word(8'h33, 1'b0);
		queue_word(8'h81, 1'b0);
		queue_word(8'h01, 1'b0);
		queue_word(8'h44, 1'b0);
		wait_drained();
		settings_used++;

		// empty frame: everything lands outside, start row wraps
		write_reg(REG_WIDTH, 12'd0);
		write_reg(REG_HEIGHT, 12'd0);
		write_reg(REG_FLIP, 12'd0);
		@(negedge clk);
		queue_word(8'h01, 1'b1);
		queue_word(8'h99, 1'b0);
		queue_word(END_OF_ROW, 1'b1);
		wait_drained();
		settings_used++;

		// largest offsets: bottom row of a 2048 by 2048 frame
		write_reg(REG_WIDTH, 12'd2048);
		write_reg(REG_HEIGHT, 12'hFFF);
		@(negedge clk);
		queue_word(8'h02, 1'b1);
		queue_word(8'h12, 1'b0);
		queue_word(8'h34, 1'b0);
		wait_drained();
		settings_used++;

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_reg(REG_WIDTH, pick_dim());
			write_reg(REG_HEIGHT, pick_dim());
			write_reg(REG_FLIP, 12'($urandom_range(0, 1)));
			settings_used++;
			@(negedge clk);
			if (phase == RANDOM_PHASES - 1) begin
				src_odds = 0;
				sink_odds = 0;
			end else begin
				src_odds = (phase % 3 == 0) ? 0 : $urandom_range(5, 35);
				sink_odds = (phase % 4 == 1) ? 0 : $urandom_range(5, 35);
			end
			queued = 0;
			if (phase == 4) begin
				// long sink stall while the source keeps offering literals
				src_odds = 0;
				hold_req++;
				queued += queue_sprite_frame(60, FRAME_LITERAL);
			end
			while (queued < PHASE_BYTES) begin
				style = (phase % 5 == 2 && queued == 0) ? FRAME_SKIP
					: ($urandom_range(0, 3) == 0) ? FRAME_LITERAL : FRAME_MIXED;
				queued += queue_sprite_frame($urandom_range(10, 50), style);
			end
			wait_drained();
		end

		if (writes_due.size() != 0)
			flag_mismatch($sformatf("%0d pixel writes never arrived", writes_due.size()));
		$display("Fed %0d coded bytes under %0d register settings.", bytes_fed, settings_used);
		$display("Checked %0d pixel writes, %0d of them flagged outside the frame.",
			writes_checked, outside_seen);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/srle_pkg.sv
sv/srle_front.sv
sv/srle_fifo.sv
sv/srle_back.sv
sv/sprite_rle_frame_decoder_top.sv
tb/tb.sv
